/* rtl/core/fisp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fisp_pkg
// Shared types and constants of the framed image stream parser.
// ----------------------------------------------------------------------------
package fisp_pkg;

   localparam int MAX_RECTS = 10;
   localparam int RIDX_W    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
   localparam int RCNT_W    = $clog2(MAX_RECTS + 1);

   localparam int PRE_LEN  = 8;
   localparam int HDR_LEN  = 6;
   localparam int RECT_LEN = 9;
   localparam int BIP_W    = 4;
   localparam int RECT_W   = 8 * RECT_LEN;

   localparam logic [7:0] PREAMBLE [PRE_LEN] =
      '{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07};
   localparam logic [7:0] WHITE_BYTE = 8'hFF;

   localparam logic [15:0] WIDTH_RESET  = 16'd1872;
   localparam logic [15:0] HEIGHT_RESET = 16'd1404;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXP_HEIGHT = 1'd1;

   localparam logic [2:0] RK_PIXEL = 3'd0;
   localparam logic [2:0] RK_RECT  = 3'd1;
   localparam logic [2:0] RK_DONE  = 3'd2;
   localparam logic [2:0] RK_STOP  = 3'd3;
   localparam logic [2:0] RK_ERROR = 3'd4;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_EOS      = 2'd1;
   localparam logic [1:0] ERR_PREAMBLE = 2'd2;
   localparam logic [1:0] ERR_HEADER   = 2'd3;

   typedef enum logic [2:0] {
      ST_PRE,
      ST_HDR,
      ST_RECT,
      ST_PIX,
      ST_EMIT,
      ST_HALT
   } state_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_PRE,
      OP_HDR,
      OP_RECT,
      OP_PIX
   } dp_op_type;

   typedef enum logic [2:0] {
      RS_PIXEL,
      RS_RECT,
      RS_DONE,
      RS_STOP,
      RS_ERROR
   } rsp_sel_type;

   typedef struct packed {
      dp_op_type   op;
      logic        bip_clr;
      logic        frame_clr;
      logic        emit_step;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
      logic [1:0]  err_code;
      logic        rsp_last;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic pre_last;
      logic pre_ok;
      logic hdr_last;
      logic stop_flag;
      logic hdr_bad;
      logic cnt_zero;
      logic empty_payload;
      logic rect_end;
      logic rect_last;
      logic pix_last;
      logic emit_more;
   } dp_status_type;

endpackage
`default_nettype wire

/* rtl/core/fisp_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fisp_ctrl
// Frame sequencer: tracks the frame phase, issues datapath commands and
// steps through the rectangle/done burst at frame end.
// ----------------------------------------------------------------------------
module fisp_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_kind,
   output logic                        req_ready,
   input  wire fisp_pkg::dp_status_type status,
   output fisp_pkg::dp_cmd_type        cmd
);

   fisp_pkg::state_type state_ff, state_in;
   logic                accept;

   assign req_ready = (state_ff != fisp_pkg::ST_EMIT) && status.out_free;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fisp_pkg::ST_PRE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fisp_pkg::ST_PRE: begin
            if (accept) begin
               if (req_kind) begin
                  state_in = fisp_pkg::ST_HALT;
               end else if (status.pre_last) begin
                  state_in = status.pre_ok ? fisp_pkg::ST_HDR : fisp_pkg::ST_HALT;
               end
            end
         end
         fisp_pkg::ST_HDR: begin
            if (accept) begin
               if (req_kind) begin
                  state_in = fisp_pkg::ST_HALT;
               end else if (status.hdr_last) begin
                  priority if (status.stop_flag || status.hdr_bad) begin
                     state_in = fisp_pkg::ST_HALT;
                  end else if (!status.cnt_zero) begin
                     state_in = fisp_pkg::ST_RECT;
                  end else if (status.empty_payload) begin
                     state_in = fisp_pkg::ST_EMIT;
                  end else begin
                     state_in = fisp_pkg::ST_PIX;
                  end
               end
            end
         end
         fisp_pkg::ST_RECT: begin
            if (accept) begin
               if (req_kind) begin
                  state_in = fisp_pkg::ST_HALT;
               end else if (status.rect_last) begin
                  state_in = status.empty_payload ? fisp_pkg::ST_EMIT : fisp_pkg::ST_PIX;
               end
            end
         end
         fisp_pkg::ST_PIX: begin
            if (accept) begin
               if (req_kind) begin
                  state_in = fisp_pkg::ST_HALT;
               end else if (status.pix_last) begin
                  state_in = fisp_pkg::ST_EMIT;
               end
            end
         end
         fisp_pkg::ST_EMIT: begin
            if (status.out_free && !status.emit_more) begin
               state_in = fisp_pkg::ST_PRE;
            end
         end
         fisp_pkg::ST_HALT: begin
            state_in = fisp_pkg::ST_HALT;
         end
         default: begin
            state_in = fisp_pkg::ST_HALT;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd           = '0;
      cmd.op        = fisp_pkg::OP_IDLE;
      cmd.rsp_sel   = fisp_pkg::RS_PIXEL;
      cmd.err_code  = fisp_pkg::ERR_NONE;
      unique case (state_ff)
         fisp_pkg::ST_PRE, fisp_pkg::ST_HDR, fisp_pkg::ST_RECT, fisp_pkg::ST_PIX: begin
            if (accept && req_kind) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = fisp_pkg::RS_ERROR;
               cmd.err_code = fisp_pkg::ERR_EOS;
               cmd.rsp_last = 1'b1;
            end else if (accept) begin
               unique case (state_ff)
                  fisp_pkg::ST_PRE: begin
                     cmd.op      = fisp_pkg::OP_PRE;
                     cmd.bip_clr = status.pre_last;
                     if (status.pre_last && !status.pre_ok) begin
                        cmd.rsp_load = 1'b1;
                        cmd.rsp_sel  = fisp_pkg::RS_ERROR;
                        cmd.err_code = fisp_pkg::ERR_PREAMBLE;
                        cmd.rsp_last = 1'b1;
                     end
                  end
                  fisp_pkg::ST_HDR: begin
                     cmd.op      = fisp_pkg::OP_HDR;
                     cmd.bip_clr = status.hdr_last;
                     if (status.hdr_last) begin
                        priority if (status.stop_flag) begin
                           cmd.rsp_load = 1'b1;
                           cmd.rsp_sel  = fisp_pkg::RS_STOP;
                           cmd.rsp_last = 1'b1;
                        end else if (status.hdr_bad) begin
                           cmd.rsp_load = 1'b1;
                           cmd.rsp_sel  = fisp_pkg::RS_ERROR;
                           cmd.err_code = fisp_pkg::ERR_HEADER;
                           cmd.rsp_last = 1'b1;
                        end else begin
                           cmd.rsp_load = 1'b0;
                        end
                     end
                  end
                  fisp_pkg::ST_RECT: begin
                     cmd.op      = fisp_pkg::OP_RECT;
                     // byte counter restarts at the end of every record
                     cmd.bip_clr = status.rect_end;
                  end
                  default: begin
                     cmd.op       = fisp_pkg::OP_PIX;
                     cmd.rsp_load = 1'b1;
                     cmd.rsp_sel  = fisp_pkg::RS_PIXEL;
                     cmd.rsp_last = !status.pix_last;
                  end
               endcase
            end
         end
         fisp_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.rsp_load = 1'b1;
               if (status.emit_more) begin
                  cmd.rsp_sel   = fisp_pkg::RS_RECT;
                  cmd.emit_step = 1'b1;
               end else begin
                  cmd.rsp_sel   = fisp_pkg::RS_DONE;
                  cmd.rsp_last  = 1'b1;
                  cmd.frame_clr = 1'b1;
               end
            end
         end
         default: begin
            cmd.op = fisp_pkg::OP_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/fisp_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fisp_dp
// Parser datapath: byte counters, header capture, rectangle store, payload
// offset and tally, size checks and the result output register.
// ----------------------------------------------------------------------------
module fisp_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wr_en,
   input  wire logic [fisp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fisp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [7:0]                    req_data_byte,
   input  wire fisp_pkg::dp_cmd_type          cmd,
   output fisp_pkg::dp_status_type            status,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic [2:0]                         rsp_result_kind,
   output logic [1:0]                         rsp_error_code,
   output logic [30:0]                        rsp_pixel_offset,
   output logic [7:0]                         rsp_pixel_byte,
   output logic [15:0]                        rsp_rect_x,
   output logic [15:0]                        rsp_rect_y,
   output logic [15:0]                        rsp_rect_w,
   output logic [15:0]                        rsp_rect_h,
   output logic [7:0]                         rsp_display_mode,
   output logic [30:0]                        rsp_nonwhite_count,
   output logic                               rsp_last
);

   logic [15:0]                  exp_w_ff, exp_h_ff;
   logic [fisp_pkg::BIP_W-1:0]   bip_ff, bip_in;
   logic                         pre_ok_ff, pre_ok_in;
   logic [39:0]                  header_ff;
   logic [7:0]                   cnt_ff;
   logic [31:0]                  prod_ff;
   logic [fisp_pkg::RCNT_W-1:0]  rect_idx_ff, rect_idx_in, rect_idx_inc;
   logic [fisp_pkg::RCNT_W-1:0]  emit_idx_ff, emit_idx_in;
   logic [30:0]                  offset_ff, offset_in, offset_inc;
   logic [30:0]                  tally_ff, tally_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [fisp_pkg::RECT_W-1:0]  rect_ff [fisp_pkg::MAX_RECTS];
   logic [fisp_pkg::RECT_W-1:0]  rect_rd;
   logic [15:0]                  hdr_w, hdr_h;
   logic                         byte_match;

   // header_ff holds stop, width, height once the fifth header byte is in
   assign hdr_w        = header_ff[31:16];
   assign hdr_h        = header_ff[15:0];
   assign byte_match   = (req_data_byte == fisp_pkg::PREAMBLE[bip_ff[2:0]]);
   assign rect_idx_inc = rect_idx_ff + 1'b1;
   assign offset_inc   = offset_ff + 31'd1;
   assign rect_rd      = rect_ff[emit_idx_ff[fisp_pkg::RIDX_W-1:0]];

   always_comb begin
      status               = '0;
      status.out_free      = !rsp_valid_ff || rsp_ready;
      status.pre_last      = (bip_ff == fisp_pkg::BIP_W'(fisp_pkg::PRE_LEN - 1));
      status.pre_ok        = pre_ok_ff && byte_match;
      status.hdr_last      = (bip_ff == fisp_pkg::BIP_W'(fisp_pkg::HDR_LEN - 1));
      status.stop_flag     = (header_ff[39:32] != 8'd0);
      status.hdr_bad       = (hdr_w != exp_w_ff) || (hdr_h != exp_h_ff) ||
                             (req_data_byte > 8'(fisp_pkg::MAX_RECTS));
      status.cnt_zero      = (req_data_byte == 8'd0);
      // w*h/2 is zero only when w*h is 0 or 1
      status.empty_payload = (hdr_w == 16'd0) || (hdr_h == 16'd0) ||
                             ((hdr_w == 16'd1) && (hdr_h == 16'd1));
      status.rect_end      = (bip_ff == fisp_pkg::BIP_W'(fisp_pkg::RECT_LEN - 1));
      status.rect_last     = (bip_ff == fisp_pkg::BIP_W'(fisp_pkg::RECT_LEN - 1)) &&
                             (8'(rect_idx_inc) >= cnt_ff);
      status.pix_last      = (offset_inc >= prod_ff[31:1]);
      status.emit_more     = (8'(emit_idx_ff) < cnt_ff);
   end

   always_comb begin
      bip_in      = bip_ff;
      pre_ok_in   = pre_ok_ff;
      rect_idx_in = rect_idx_ff;
      emit_idx_in = emit_idx_ff;
      offset_in   = offset_ff;
      tally_in    = tally_ff;
      if (cmd.op != fisp_pkg::OP_IDLE) begin
         bip_in = cmd.bip_clr ? '0 : bip_ff + 1'b1;
      end
      if (cmd.op == fisp_pkg::OP_PRE) begin
         pre_ok_in = status.pre_ok;
      end
      if (cmd.op == fisp_pkg::OP_RECT && cmd.bip_clr) begin
         rect_idx_in = rect_idx_inc;
      end
      if (cmd.op == fisp_pkg::OP_PIX) begin
         offset_in = offset_inc;
         if (req_data_byte != fisp_pkg::WHITE_BYTE) begin
            tally_in = tally_ff + 31'd1;
         end
      end
      if (cmd.emit_step) begin
         emit_idx_in = emit_idx_ff + 1'b1;
      end
      if (cmd.frame_clr) begin
         bip_in      = '0;
         pre_ok_in   = 1'b1;
         rect_idx_in = '0;
         emit_idx_in = '0;
         offset_in   = '0;
         tally_in    = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_w_ff     <= fisp_pkg::WIDTH_RESET;
         exp_h_ff     <= fisp_pkg::HEIGHT_RESET;
         bip_ff       <= '0;
         pre_ok_ff    <= 1'b1;
         rect_idx_ff  <= '0;
         emit_idx_ff  <= '0;
         offset_ff    <= '0;
         tally_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en && csr_index == fisp_pkg::CSR_EXP_WIDTH) begin
            exp_w_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == fisp_pkg::CSR_EXP_HEIGHT) begin
            exp_h_ff <= csr_wdata;
         end
         bip_ff       <= bip_in;
         pre_ok_ff    <= pre_ok_in;
         rect_idx_ff  <= rect_idx_in;
         emit_idx_ff  <= emit_idx_in;
         offset_ff    <= offset_in;
         tally_ff     <= tally_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // header capture, size product and rectangle store
   always_ff @(posedge clock) begin
      prod_ff <= 32'(hdr_w) * 32'(hdr_h);
      if (cmd.op == fisp_pkg::OP_HDR) begin
         if (status.hdr_last) begin
            cnt_ff <= req_data_byte;
         end else begin
            header_ff <= {header_ff[31:0], req_data_byte};
         end
      end
      if (cmd.op == fisp_pkg::OP_RECT) begin
         for (int k = 0; k < fisp_pkg::RECT_LEN; k++) begin
            if (bip_ff == fisp_pkg::BIP_W'(k)) begin
               rect_ff[rect_idx_ff[fisp_pkg::RIDX_W-1:0]]
                  [(fisp_pkg::RECT_LEN - 1 - k) * 8 +: 8] <= req_data_byte;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_error_code     <= fisp_pkg::ERR_NONE;
         rsp_pixel_offset   <= '0;
         rsp_pixel_byte     <= '0;
         rsp_rect_x         <= '0;
         rsp_rect_y         <= '0;
         rsp_rect_w         <= '0;
         rsp_rect_h         <= '0;
         rsp_display_mode   <= '0;
         rsp_nonwhite_count <= '0;
         rsp_last           <= cmd.rsp_last;
         unique case (cmd.rsp_sel)
            fisp_pkg::RS_PIXEL: begin
               rsp_result_kind  <= fisp_pkg::RK_PIXEL;
               rsp_pixel_offset <= offset_ff;
               rsp_pixel_byte   <= req_data_byte;
            end
            fisp_pkg::RS_RECT: begin
               rsp_result_kind  <= fisp_pkg::RK_RECT;
               rsp_rect_x       <= rect_rd[71:56];
               rsp_rect_y       <= rect_rd[55:40];
               rsp_rect_w       <= rect_rd[39:24];
               rsp_rect_h       <= rect_rd[23:8];
               rsp_display_mode <= rect_rd[7:0];
            end
            fisp_pkg::RS_DONE: begin
               rsp_result_kind    <= fisp_pkg::RK_DONE;
               rsp_nonwhite_count <= tally_ff;
            end
            fisp_pkg::RS_STOP: begin
               rsp_result_kind <= fisp_pkg::RK_STOP;
            end
            default: begin
               rsp_result_kind <= fisp_pkg::RK_ERROR;
               rsp_error_code  <= cmd.err_code;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* rtl/core/framed_image_stream_parser.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// framed_image_stream_parser
// Frame parser for a byte stream carrying preamble, header, rectangle records
// and packed pixel payload.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per stream byte (req_kind 0) or the end of the
//   stream (req_kind 1). rsp_* carries results: pixel words, rectangles,
//   frame done, stop or error, with rsp_last on the final result of a word.
//   csr_* writes expected_width (index 0) and expected_height (index 1).
// Timing:
//   One input word per cycle while the output register is free, outside the
//   frame-end burst; a result appears in the output register in the cycle
//   after the word that causes it. After the last payload byte (or the last
//   header/rectangle byte of an empty payload) the block sends count+1 results,
//   rectangles then done, one per cycle while rsp_ready is high; req_ready low.
// Reset:
//   Synchronous; the parser waits for a preamble, registers take their
//   default panel size. After a stop or an error all input words are taken
//   and dropped until the next reset.
// Stall:
//   A waiting result blocks new input only while rsp_ready is low; the
//   output register frees in the same cycle it is taken.
// ----------------------------------------------------------------------------
module framed_image_stream_parser (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [fisp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fisp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_kind,
   input  wire logic [7:0]                      req_data_byte,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [2:0]                           rsp_result_kind,
   output logic [1:0]                           rsp_error_code,
   output logic [30:0]                          rsp_pixel_offset,
   output logic [7:0]                           rsp_pixel_byte,
   output logic [15:0]                          rsp_rect_x,
   output logic [15:0]                          rsp_rect_y,
   output logic [15:0]                          rsp_rect_w,
   output logic [15:0]                          rsp_rect_h,
   output logic [7:0]                           rsp_display_mode,
   output logic [30:0]                          rsp_nonwhite_count,
   output logic                                 rsp_last
);

   fisp_pkg::dp_cmd_type    cmd;
   fisp_pkg::dp_status_type status;

   fisp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fisp_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_data_byte      (req_data_byte),
      .cmd                (cmd),
      .status             (status),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_error_code     (rsp_error_code),
      .rsp_pixel_offset   (rsp_pixel_offset),
      .rsp_pixel_byte     (rsp_pixel_byte),
      .rsp_rect_x         (rsp_rect_x),
      .rsp_rect_y         (rsp_rect_y),
      .rsp_rect_w         (rsp_rect_w),
      .rsp_rect_h         (rsp_rect_h),
      .rsp_display_mode   (rsp_display_mode),
      .rsp_nonwhite_count (rsp_nonwhite_count),
      .rsp_last           (rsp_last)
   );

   // a new result must never overwrite one still waiting
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.out_free)
      else $error("result register loaded while occupied");

   // stop and error end the word's results
   a_halt_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == fisp_pkg::RK_STOP ||
                    rsp_result_kind == fisp_pkg::RK_ERROR) |-> rsp_last)
      else $error("stop or error result without last");

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != fisp_pkg::RK_ERROR |->
         rsp_error_code == fisp_pkg::ERR_NONE)
      else $error("error code on a non-error result");

   // input is held off while the frame-end burst runs
   a_burst_block: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_step |-> !req_ready)
      else $error("input taken during rectangle burst");

endmodule
`default_nettype wire

/* test/framed_image_stream_parser_test.sv */
// ----------------------------------------------------------------------------
// framed_image_stream_parser_test
// Self-checking bench for the frame parser. Well-formed frames with random
// rectangles and pixel words run under several small panel sizes, including
// empty payloads. Every result is checked field by field against a
// mirror of the parser. The run ends with one randomly chosen fault that
// halts the block, followed by words the halted block must drop.
// ----------------------------------------------------------------------------
module framed_image_stream_parser_test;
   import fisp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [2:0]  rkind;
      logic [1:0]  err;
      logic [30:0] offset;
      logic [7:0]  pixel;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic [7:0]  mode;
      logic [30:0] count;
      logic        last;
   } parse_result_type;

   typedef enum {
      HALT_STOP, HALT_WIDTH, HALT_HEIGHT, HALT_COUNT, HALT_PREAMBLE,
      HALT_EOS_GAP, HALT_EOS_PRE, HALT_EOS_HDR, HALT_EOS_RECT, HALT_EOS_PIX
   } halt_case_type;

   class frame_scoreboard;
      parse_result_type pending[$];
      parse_result_type step_out[$];
      int errors;
      int checked;
      logic [15:0] panel_w;
      logic [15:0] panel_h;
      state_type phase;
      int pos;
      bit mark_ok;
      logic [47:0] hdr;
      int rect_no;
      logic [63:0] geom [MAX_RECTS];
      logic [7:0] modes [MAX_RECTS];
      logic [30:0] pay_off;
      logic [30:0] pay_len;
      logic [30:0] tally;
      bit halted;

      function new();
         panel_w = WIDTH_RESET;
         panel_h = HEIGHT_RESET;
         halted = 1'b0;
         errors = 0;
         checked = 0;
         start_frame();
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
         if (idx == CSR_EXP_WIDTH) panel_w = val;
         else if (idx == CSR_EXP_HEIGHT) panel_h = val;
      endfunction

      function void start_frame();
         phase = ST_PRE;
         pos = 0;
         mark_ok = 1'b1;
         hdr = '0;
         rect_no = 0;
         pay_off = '0;
         pay_len = '0;
         tally = '0;
      endfunction

      function parse_result_type blank(logic [2:0] k);
         parse_result_type r;
         r = '0;
         r.rkind = k;
         return r;
      endfunction

      function void fault(logic [1:0] code);
         parse_result_type r;
         r = blank(RK_ERROR);
         r.err = code;
         step_out.push_back(r);
         halted = 1'b1;
      endfunction

      // stored rectangles go out in order, then frame done with the tally
      function void finish_frame();
         parse_result_type r;
         for (int i = 0; i < hdr[7:0]; i++) begin
            r = blank(RK_RECT);
            {r.x, r.y, r.w, r.h} = geom[i];
            r.mode = modes[i];
            step_out.push_back(r);
         end
         r = blank(RK_DONE);
         r.count = tally;
         step_out.push_back(r);
         start_frame();
      endfunction

      function void close_rects();
         if (pay_len == 0) finish_frame();
         else phase = ST_PIX;
      endfunction

      function void take_stream_word(logic stream_end, logic [7:0] b);
         parse_result_type r;
         logic [31:0] area;
         if (halted) return;
         step_out.delete();
         if (stream_end) begin
            fault(ERR_EOS);
         end else begin
            case (phase)
               ST_PRE: begin
                  if (b != PREAMBLE[pos]) mark_ok = 1'b0;
                  pos++;
                  if (pos == PRE_LEN) begin
                     pos = 0;
                     if (!mark_ok) fault(ERR_PREAMBLE);
                     else phase = ST_HDR;
                  end
               end
               ST_HDR: begin
                  hdr = {hdr[39:0], b};
                  pos++;
                  if (pos == HDR_LEN) begin
                     pos = 0;
                     // stop flag wins over the size and count checks
                     if (hdr[47:40] != 8'h00) begin
                        step_out.push_back(blank(RK_STOP));
                        halted = 1'b1;
                     end else if (hdr[39:24] != panel_w || hdr[23:8] != panel_h ||
                                  hdr[7:0] > MAX_RECTS) begin
                        fault(ERR_HEADER);
                     end else begin
                        area = 32'(hdr[39:24]) * 32'(hdr[23:8]);
                        pay_len = area[31:1];
                        rect_no = 0;
                        if (hdr[7:0] != 0) phase = ST_RECT;
                        else close_rects();
                     end
                  end
               end
               ST_RECT: begin
                  if (pos < 8) geom[rect_no][63-8*pos -: 8] = b;
                  else modes[rect_no] = b;
                  pos++;
                  if (pos == RECT_LEN) begin
                     pos = 0;
                     rect_no++;
                     if (rect_no >= hdr[7:0]) close_rects();
                  end
               end
               default: begin
                  r = blank(RK_PIXEL);
                  r.offset = pay_off;
                  r.pixel = b;
                  step_out.push_back(r);
                  if (b != WHITE_BYTE) tally++;
                  pay_off++;
                  if (pay_off >= pay_len) finish_frame();
               end
            endcase
         end
         if (step_out.size() > 0) begin
            step_out[step_out.size()-1].last = 1'b1;
            foreach (step_out[i]) pending.push_back(step_out[i]);
         end
      endfunction

      task report(string msg);
         $display("%0t: mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
      endtask

      task check_result(parse_result_type got);
         parse_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("result of kind %0d with nothing expected", got.rkind));
            return;
         end
         want = pending.pop_front();
         check_field("result_kind", 64'(got.rkind), 64'(want.rkind));
         check_field("error_code", 64'(got.err), 64'(want.err));
         check_field("pixel_offset", 64'(got.offset), 64'(want.offset));
         check_field("pixel_byte", 64'(got.pixel), 64'(want.pixel));
         check_field("rect_x", 64'(got.x), 64'(want.x));
         check_field("rect_y", 64'(got.y), 64'(want.y));
         check_field("rect_w", 64'(got.w), 64'(want.w));
         check_field("rect_h", 64'(got.h), 64'(want.h));
         check_field("display_mode", 64'(got.mode), 64'(want.mode));
         check_field("nonwhite_count", 64'(got.count), 64'(want.count));
         check_field("last", 64'(got.last), 64'(want.last));
         checked++;
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_EXP_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_kind = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_result_kind;
   logic [1:0] rsp_error_code;
   logic [30:0] rsp_pixel_offset;
   logic [7:0] rsp_pixel_byte;
   logic [15:0] rsp_rect_x;
   logic [15:0] rsp_rect_y;
   logic [15:0] rsp_rect_w;
   logic [15:0] rsp_rect_h;
   logic [7:0] rsp_display_mode;
   logic [30:0] rsp_nonwhite_count;
   logic rsp_last;

   frame_scoreboard board = new();
   logic [7:0] burst[$];
   logic [15:0] cur_w = WIDTH_RESET;
   logic [15:0] cur_h = HEIGHT_RESET;
   bit calm = 1'b0;
   int stream_words = 0;
   int idle_cycles = 0;

   framed_image_stream_parser dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_error_code(rsp_error_code),
      .rsp_pixel_offset(rsp_pixel_offset),
      .rsp_pixel_byte(rsp_pixel_byte),
      .rsp_rect_x(rsp_rect_x),
      .rsp_rect_y(rsp_rect_y),
      .rsp_rect_w(rsp_rect_w),
      .rsp_rect_h(rsp_rect_h),
      .rsp_display_mode(rsp_display_mode),
      .rsp_nonwhite_count(rsp_nonwhite_count),
      .rsp_last(rsp_last)
   );

   always #2 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_pixel();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return WHITE_BYTE;
      if (r == 3) return 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [15:0] rand_field();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) return 16'h0000;
      if (r < 4) return 16'hFFFF;
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic void put_head(logic [7:0] stop, logic [15:0] w, logic [15:0] h,
                                    logic [7:0] cnt);
      for (int i = 0; i < PRE_LEN; i++) burst.push_back(PREAMBLE[i]);
      burst.push_back(stop);
      burst.push_back(w[15:8]);
      burst.push_back(w[7:0]);
      burst.push_back(h[15:8]);
      burst.push_back(h[7:0]);
      burst.push_back(cnt);
   endfunction

   function automatic void put_rect(logic [15:0] x, logic [15:0] y, logic [15:0] w,
                                    logic [15:0] h, logic [7:0] mode);
      logic [71:0] rec;
      rec = {x, y, w, h, mode};
      for (int i = RECT_LEN - 1; i >= 0; i--) burst.push_back(rec[8*i +: 8]);
   endfunction

   function automatic void put_body(int cnt);
      logic [31:0] area;
      area = 32'(cur_w) * 32'(cur_h);
      repeat (cnt) put_rect(rand_field(), rand_field(), rand_field(), rand_field(),
                            8'($urandom_range(0, 255)));
      repeat (area[31:1]) burst.push_back(rand_pixel());
   endfunction

   // valid is raised at a falling edge and held until taken at a rising edge
   task automatic send_word(logic k, logic [7:0] d);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_data_byte <= d;
      do @(posedge clock); while (!req_ready);
      board.take_stream_word(k, d);
      stream_words++;
   endtask

   task automatic send_burst();
      foreach (burst[i]) send_word(1'b0, burst[i]);
      burst.delete();
   endtask

   task automatic send_frame(int cnt);
      put_head(8'h00, cur_w, cur_h, 8'(cnt));
      put_body(cnt);
      send_burst();
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_panel(logic [15:0] w, logic [15:0] h);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_EXP_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= CSR_EXP_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      board.set_reg(CSR_EXP_WIDTH, w);
      board.set_reg(CSR_EXP_HEIGHT, h);
      cur_w = w;
      cur_h = h;
   endtask

   // one fault per run, since only reset clears the halt
   task automatic halt_block();
      halt_case_type how;
      int cnt;
      int keep;
      int at;
      logic [31:0] area;
      bit eos;
      how = halt_case_type'($urandom_range(0, 9));
      write_panel(16'($urandom_range(2, 8)), 16'($urandom_range(2, 8)));
      cnt = $urandom_range(1, MAX_RECTS);
      area = 32'(cur_w) * 32'(cur_h);
      eos = 1'b0;
      case (how)
         HALT_STOP:
            put_head(8'($urandom_range(1, 255)), rand_field(), rand_field(),
                     8'($urandom_range(0, 255)));
         HALT_WIDTH:
            put_head(8'h00, cur_w ^ (16'h1 << $urandom_range(0, 15)), cur_h, 8'(cnt));
         HALT_HEIGHT:
            put_head(8'h00, cur_w, cur_h ^ (16'h1 << $urandom_range(0, 15)), 8'(cnt));
         HALT_COUNT:
            put_head(8'h00, cur_w, cur_h, 8'($urandom_range(MAX_RECTS + 1, 255)));
         HALT_PREAMBLE: begin
            put_head(8'h00, cur_w, cur_h, 8'(cnt));
            at = $urandom_range(0, PRE_LEN - 1);
            burst[at] = burst[at] ^ 8'($urandom_range(1, 255));
         end
         default: begin
            eos = 1'b1;
            put_head(8'h00, cur_w, cur_h, 8'(cnt));
            put_body(cnt);
            case (how)
               HALT_EOS_GAP: keep = 0;
               HALT_EOS_PRE: keep = $urandom_range(1, PRE_LEN - 1);
               HALT_EOS_HDR: keep = PRE_LEN + $urandom_range(1, HDR_LEN - 1);
               HALT_EOS_RECT:
                  keep = PRE_LEN + HDR_LEN + $urandom_range(1, RECT_LEN * cnt - 1);
               default:
                  keep = PRE_LEN + HDR_LEN + RECT_LEN * cnt +
                         $urandom_range(1, area[31:1] - 1);
            endcase
            while (burst.size() > keep) void'(burst.pop_back());
         end
      endcase
      send_burst();
      if (eos) send_word(1'b1, 8'($urandom_range(0, 255)));
      // halted: everything below must be taken and dropped
      send_word(1'b1, 8'($urandom_range(0, 255)));
      repeat (23) send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
   endtask

   // receiver: long ready stretches now and then, short and long stalls
   initial begin
      int run;
      int stall;
      @(negedge clock);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
         stall = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
         rsp_ready <= 1'b1;
         repeat (run) @(negedge clock);
         rsp_ready <= 1'b0;
         repeat (stall) @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      parse_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.rkind = rsp_result_kind;
         got.err = rsp_error_code;
         got.offset = rsp_pixel_offset;
         got.pixel = rsp_pixel_byte;
         got.x = rsp_rect_x;
         got.y = rsp_rect_y;
         got.w = rsp_rect_w;
         got.h = rsp_rect_h;
         got.mode = rsp_display_mode;
         got.count = rsp_nonwhite_count;
         got.last = rsp_last;
         board.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("framed_image_stream_parser_test: errors");
         $finish;
      end
   end

   initial begin
      int frames_left;
      int r;
      int cnt;
      bit first;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty payloads: done right after the header, then after the rectangles
      write_panel(16'd1, 16'd1);
      send_frame(0);
      put_head(8'h00, cur_w, cur_h, 8'd2);
      put_rect(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 8'hFF);
      put_rect(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h00);
      send_burst();

      frames_left = 0;
      first = 1'b1;
      while (stream_words < 250) begin
         if (frames_left == 0) begin
            if ($urandom_range(0, 4) == 0) write_panel(16'd1, 16'($urandom_range(1, 2)));
            else write_panel(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
            frames_left = $urandom_range(1, 3);
         end
         calm = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (first || r < 15) cnt = MAX_RECTS;
         else if (r < 35) cnt = 0;
         else cnt = $urandom_range(1, 3);
         first = 1'b0;
         send_frame(cnt);
         frames_left--;
      end
      calm = 1'b0;

      halt_block();

      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (board.errors == 0) begin
         $display("framed_image_stream_parser_test: clean");
      end else begin
         $display("framed_image_stream_parser_test: errors");
      end
      $finish;
   end

endmodule
